### rtl/dad_pkg.sv
// Package for the date advance block: request and response payload types,
// sequencer state type, status codes and calendar helper functions.
// Depends on nothing; dad_ctrl and date_add_days_core import it.
package dad_pkg;

   // Calendar limits.
   localparam logic [13:0] FIRST_VALID_YEAR = 14'd1583;
   localparam logic [13:0] MAX_YEAR         = 14'd16383;

   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_APR = 4'd4;
   localparam logic [3:0]  MONTH_JUN = 4'd6;
   localparam logic [3:0]  MONTH_SEP = 4'd9;
   localparam logic [3:0]  MONTH_NOV = 4'd11;
   localparam logic [3:0]  MONTH_DEC = 4'd12;

   // Reciprocal of 400 scaled by 2**21, exact for any 14-bit year.
   localparam logic [12:0] RECIP_400       = 13'd5243;
   localparam int          RECIP_400_SHIFT = 21;

   // Response status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [4:0]  start_day;
      logic [3:0]  start_month;
      logic [13:0] start_year;
      logic [15:0] days_to_add;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  result_day;
      logic [3:0]  result_month;
      logic [13:0] result_year;
      logic [1:0]  status;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODINIT,
      ST_CHECK,
      ST_RUN,
      ST_DONE
   } dad_state_type;

   // Days in a month; months outside 1 to 12 read as 31.
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         unique case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd31;
         endcase
         return len;
      end
   endfunction

   // Days in a year.
   function automatic logic [8:0] year_len(input logic leap);
      return leap ? 9'd366 : 9'd365;
   endfunction

endpackage

### rtl/dad_alu.sv
// Shared compare and subtract unit of the date advance block.
// Compares the remaining day count against a span and forms the difference.
// Depends on nothing outside this file.
module dad_alu (
   input  logic [15:0] rem,
   input  logic [8:0]  span,
   output logic        more,
   output logic [15:0] diff
);

   logic [16:0] wide_diff;

   // One 17-bit subtract gives both the borrow and the difference.
   assign wide_diff = {1'b0, rem} - {8'd0, span};
   assign more      = !wide_diff[16] && (wide_diff[15:0] != 16'd0);
   assign diff      = wide_diff[15:0];

endmodule

### rtl/dad_ctrl.sv
// Sequencer and date registers of the date advance block.
// Validates the start date, then steps by whole years or months through dad_alu.
// Depends on dad_pkg and dad_alu.
module dad_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  dad_pkg::req_payload_type req_data,
   input  logic                     slot_free,
   output logic                     idle,
   output logic                     rsp_load,
   output dad_pkg::rsp_payload_type rsp_data
);
   import dad_pkg::*;

   dad_state_type state_ff, state_in;

   logic [4:0]  day_ff,    day_in;
   logic [3:0]  month_ff,  month_in;
   logic [13:0] year_ff,   year_in;
   logic [15:0] rem_ff,    rem_in;
   logic [1:0]  status_ff, status_in;
   logic [26:0] prod_ff,   prod_in;
   logic [8:0]  c400_ff,   c400_in;
   logic [6:0]  c100_ff,   c100_in;
   logic        no_skip_ff, no_skip_in;

   logic        leap;
   logic [4:0]  mlen;
   logic [4:0]  left;
   logic        year_skip;
   logic [8:0]  span;
   logic        more;
   logic [15:0] diff;
   logic        run_done;
   logic        date_bad;
   logic [5:0]  quot;
   logic [14:0] quot_x400;
   logic [14:0] mod400_wide;
   logic [8:0]  mod400;
   logic [8:0]  c400_inc;
   logic [6:0]  c100_inc;

   // Leap rule from the running residues of the year.
   assign leap = ((year_ff[1:0] == 2'd0) && (c100_ff != 7'd0)) || (c400_ff == 9'd0);
   assign mlen = month_len(month_ff, leap);
   assign left = mlen - day_ff;

   // A whole year may be skipped from the first of January, below the last year.
   assign year_skip = (day_ff == 5'd0) && (month_ff == MONTH_JAN) &&
                      (year_ff != MAX_YEAR) && !no_skip_ff;
   assign span      = year_skip ? year_len(leap) : {4'd0, left};

   dad_alu u_alu (
      .rem  (rem_ff),
      .span (span),
      .more (more),
      .diff (diff)
   );

   // Run ends when the count fits this month, or on overflow past the last year.
   assign run_done = !year_skip &&
                     (!more || ((month_ff == MONTH_DEC) && (year_ff == MAX_YEAR)));

   assign date_bad = (year_ff < FIRST_VALID_YEAR) || (month_ff == 4'd0) ||
                     (month_ff > MONTH_DEC) || (day_ff == 5'd0) || (day_ff > mlen);

   // Residues of the start year from the registered reciprocal product.
   assign quot        = prod_ff[RECIP_400_SHIFT +: 6];
   assign quot_x400   = 15'(quot) * 15'd400;
   assign mod400_wide = {1'b0, year_ff} - quot_x400;
   assign mod400      = mod400_wide[8:0];

   assign c400_inc = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
   assign c100_inc = (c100_ff == 7'd99)  ? 7'd0 : c100_ff + 7'd1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (start) state_in = ST_MODINIT;
         ST_MODINIT: state_in = ST_CHECK;
         ST_CHECK:   state_in = date_bad ? ST_DONE : ST_RUN;
         ST_RUN:     if (run_done) state_in = ST_DONE;
         ST_DONE:    if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath next values.
   always_comb begin
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      rem_in     = rem_ff;
      status_in  = status_ff;
      prod_in    = prod_ff;
      c400_in    = c400_ff;
      c100_in    = c100_ff;
      no_skip_in = no_skip_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               day_in     = req_data.start_day;
               month_in   = req_data.start_month;
               year_in    = req_data.start_year;
               rem_in     = req_data.days_to_add;
               prod_in    = 27'(req_data.start_year) * 27'(RECIP_400);
               no_skip_in = 1'b0;
            end
         end
         ST_MODINIT: begin
            c400_in = mod400;
            if (mod400 >= 9'd300) begin
               c100_in = 7'(mod400 - 9'd300);
            end else if (mod400 >= 9'd200) begin
               c100_in = 7'(mod400 - 9'd200);
            end else if (mod400 >= 9'd100) begin
               c100_in = 7'(mod400 - 9'd100);
            end else begin
               c100_in = mod400[6:0];
            end
         end
         ST_CHECK: begin
            if (date_bad) begin
               day_in    = 5'd0;
               month_in  = 4'd0;
               year_in   = 14'd0;
               status_in = STATUS_INVALID;
            end else begin
               status_in = STATUS_OK;
            end
         end
         ST_RUN: begin
            if (year_skip) begin
               if (more) begin
                  rem_in  = diff;
                  year_in = year_ff + 14'd1;
                  c400_in = c400_inc;
                  c100_in = c100_inc;
               end else begin
                  // The count ends within this year: finish month by month.
                  no_skip_in = 1'b1;
               end
            end else if (!more) begin
               day_in = day_ff + rem_ff[4:0];
            end else if (month_ff == MONTH_DEC) begin
               if (year_ff == MAX_YEAR) begin
                  day_in    = 5'd31;
                  status_in = STATUS_OVERFLOW;
               end else begin
                  rem_in   = diff;
                  day_in   = 5'd0;
                  month_in = MONTH_JAN;
                  year_in  = year_ff + 14'd1;
                  c400_in  = c400_inc;
                  c100_in  = c100_inc;
               end
            end else begin
               rem_in   = diff;
               day_in   = 5'd0;
               month_in = month_ff + 4'd1;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff     <= day_in;
      month_ff   <= month_in;
      year_ff    <= year_in;
      rem_ff     <= rem_in;
      status_ff  <= status_in;
      prod_ff    <= prod_in;
      c400_ff    <= c400_in;
      c100_ff    <= c100_in;
      no_skip_ff <= no_skip_in;
   end

   // Outputs.
   always_comb begin
      idle                  = (state_ff == ST_IDLE);
      rsp_load              = (state_ff == ST_DONE) && slot_free;
      rsp_data.result_day   = day_ff;
      rsp_data.result_month = month_ff;
      rsp_data.result_year  = year_ff;
      rsp_data.status       = status_ff;
   end

endmodule

### rtl/date_add_days_core.sv
// Top level of the date advance block: request and response handshakes and
// the response register. Depends on dad_pkg and dad_ctrl.
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_ready   req_payload (dad_pkg::req_payload_type)
//   rsp_      out         rsp_valid/rsp_ready   rsp_payload (dad_pkg::rsp_payload_type)
//
// A request passes the residue set-up and the date check. An invalid start date
// then goes straight to the response; a valid one steps through the whole years
// skipped and the months stepped, with an extra step when the count ends in a
// later year below the last one, each on the single shared compare and subtract unit.
// req_ready is high only while the sequencer is idle. A finished response sits
// in its own register, so a new request is taken while rsp_ready is low.
// Synchronous active-high reset clears the sequencer and the response valid.
module date_add_days_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dad_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dad_pkg::rsp_payload_type rsp_payload
);
   import dad_pkg::*;

   logic            idle;
   logic            start;
   logic            slot_free;
   logic            rsp_load;
   rsp_payload_type rsp_data;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   assign req_ready = idle;
   assign start     = req_valid && idle;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   dad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_payload),
      .slot_free (slot_free),
      .idle      (idle),
      .rsp_load  (rsp_load),
      .rsp_data  (rsp_data)
   );

   // Response register: loaded when the sequencer finishes and the slot is free.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = rsp_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
